// ===== sv/u8u16_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// UTF-8 to UTF-16 decoder package
// Shared result kinds, code point constants and the result and write request
// structures used by the decoder core, the result buffer and the result channel.
// ============================================================================
package u8u16_pkg;

    // Kind of one result.
    typedef enum logic [1:0] {
        KIND_UNIT    = 2'd0,
        KIND_END_OK  = 2'd1,
        KIND_END_ERR = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;

    // Result buffer size. The pointers wrap by overflow, so this stays a
    // power of two, and at least four so that two bytes in flight fit.
    localparam int RES_DEPTH = 8;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // One result as it leaves the block.
    typedef struct packed {
        logic [15:0] code_unit;
        t_kind       kind;
        logic        last_of_run;
    } t_result;

    // Results that one decoded byte hands to the result buffer.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_wr_req;

endpackage

// ===== sv/u8u16_byte_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// UTF-8 byte channel
// Valid/ready channel that carries one UTF-8 byte per transaction.
// ============================================================================
interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== sv/u8u16_res_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// UTF-16 result channel
// Valid/ready channel that carries one code unit or status result per
// transaction.
// ============================================================================
interface u8u16_res_if;
    import u8u16_pkg::*;

    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    t_kind       kind;
    logic        last_of_run;

    modport source (output valid, output code_unit, output kind, output last_of_run,
                    input ready);
    modport sink   (input valid, input code_unit, input kind, input last_of_run,
                    output ready);
endinterface

// ===== sv/utf8_to_utf16_decoder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// UTF-8 to UTF-16 decoder
// Decodes a zero-terminated UTF-8 byte stream into UTF-16 code units with
// error and end-of-string reporting.
// ============================================================================
// Usage:
//   i_byte_ch carries one UTF-8 byte per transaction; a zero byte ends the
//   string. o_res_ch carries one result per transaction: a code unit, an
//   error mark, or an end mark saying whether the string was good.
//   last_of_run marks the final result caused by a byte; a supplementary
//   code point gives a surrogate pair, an unfinished sequence at the
//   terminator gives an error followed by the end mark.
//   A byte is held in the input register and decoded from there; its results
//   are written to the result buffer, which drives the output channel.
//   Throughput: one byte per cycle, set by the output channel which moves
//   one result per cycle when not stalled; a surrogate pair is two results.
//   The result buffer holds eight results; input ready drops when the buffer
//   cannot absorb the worst case of the byte in decode plus a new one.
//   When the receiver stalls, results wait in the buffer and the input is
//   back-pressured once it fills. Reset empties the buffer and clears the
//   sequence state; input ready is high once reset has emptied the buffer.
// ============================================================================
module utf8_to_utf16_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8u16_byte_if.sink  i_byte_ch,
    u8u16_res_if.source o_res_ch
);
    import u8u16_pkg::*;

    logic                 w_accept;
    logic                 w_ready;
    logic                 w_pop;
    logic [RES_CNT_W-1:0] w_count;
    t_wr_req              w_wr;
    t_result              w_head;

    assign w_accept       = i_byte_ch.valid & w_ready;
    assign i_byte_ch.ready = w_ready;
    assign w_pop          = o_res_ch.valid & o_res_ch.ready;

    // Decoder core.
    u8u16_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_in_byte    (i_byte_ch.in_byte),
        .i_fifo_count (w_count),
        .o_ready      (w_ready),
        .o_wr         (w_wr)
    );

    // Result buffer.
    u8u16_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_pop   (w_pop),
        .o_valid (o_res_ch.valid),
        .o_head  (w_head),
        .o_count (w_count)
    );

    assign o_res_ch.code_unit   = w_head.code_unit;
    assign o_res_ch.kind        = w_head.kind;
    assign o_res_ch.last_of_run = w_head.last_of_run;

endmodule

// ===== sv/u8u16_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// UTF-8 decoder core
// Input register, running sequence state and the single-pass decode that
// turns one byte into zero, one or two results for the result buffer.
// ============================================================================
module u8u16_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [7:0]                        i_in_byte,
    input  logic [u8u16_pkg::RES_CNT_W-1:0]   i_fifo_count,
    output logic                              o_ready,
    output u8u16_pkg::t_wr_req                o_wr
);
    import u8u16_pkg::*;

    logic               r_in_vld;
    logic [7:0]         r_in_byte;
    logic [20:0]        r_pcp;
    logic [20:0]        n_pcp;
    logic [1:0]         r_rem;
    logic [1:0]         n_rem;
    logic               r_err;
    logic               n_err;
    logic [RES_CNT_W:0] w_need;
    t_wr_req            w_wr;

    // Accept a byte only if the buffer can take the worst case of both the
    // staged byte and the new one.
    assign w_need  = {1'b0, i_fifo_count} + (r_in_vld ? (RES_CNT_W+1)'(2) : '0);
    assign o_ready = (w_need <= (RES_CNT_W+1)'(RES_DEPTH - 2));

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_accept;
        end
        if (i_accept) begin
            r_in_byte <= i_in_byte;
        end
    end

    // Sequence state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcp <= '0;
            r_rem <= '0;
            r_err <= 1'b0;
        end else if (r_in_vld) begin
            r_pcp <= n_pcp;
            r_rem <= n_rem;
            r_err <= n_err;
        end
    end

    // Decode of the staged byte.
    always_comb begin
        logic [20:0] cp;
        logic [20:0] v;
        logic        fail;

        cp    = {r_pcp[14:0], r_in_byte[5:0]};
        v     = cp - SUPP_BASE;
        fail  = 1'b0;
        n_pcp = r_pcp;
        n_rem = r_rem;
        n_err = r_err;
        w_wr  = '0;

        if (r_in_byte == 8'd0) begin
            // Terminator closes the string and clears all state.
            if (!r_err && r_rem != 2'd0) begin
                w_wr.count = 2'd2;
                w_wr.res0  = '{code_unit: 16'd0, kind: KIND_ERROR, last_of_run: 1'b0};
                w_wr.res1  = '{code_unit: 16'd0, kind: KIND_END_ERR, last_of_run: 1'b1};
            end else begin
                w_wr.count = 2'd1;
                w_wr.res0  = '{code_unit: 16'd0,
                               kind: (r_err ? KIND_END_ERR : KIND_END_OK),
                               last_of_run: 1'b1};
            end
            n_pcp = '0;
            n_rem = '0;
            n_err = 1'b0;
        end else if (r_err) begin
            // Discarding until the terminator.
        end else if (r_rem == 2'd0) begin
            // Lead byte position.
            if (!r_in_byte[7]) begin
                w_wr.count = 2'd1;
                w_wr.res0  = '{code_unit: {8'd0, r_in_byte}, kind: KIND_UNIT,
                               last_of_run: 1'b1};
            end else if (r_in_byte[7:5] == 3'b110) begin
                n_pcp = {16'd0, r_in_byte[4:0]};
                n_rem = 2'd1;
            end else if (r_in_byte[7:4] == 4'b1110) begin
                n_pcp = {17'd0, r_in_byte[3:0]};
                n_rem = 2'd2;
            end else if (r_in_byte[7:3] == 5'b11110) begin
                n_pcp = {18'd0, r_in_byte[2:0]};
                n_rem = 2'd3;
            end else begin
                fail = 1'b1;
            end
        end else if (r_in_byte[7:6] != 2'b10) begin
            fail = 1'b1;
        end else begin
            // Continuation byte.
            n_rem = r_rem - 2'd1;
            if (r_rem != 2'd1) begin
                n_pcp = cp;
            end else begin
                n_pcp = '0;
                if (cp[20:16] == 5'd0) begin
                    if (cp[15:11] == 5'b11011) begin
                        fail = 1'b1;
                    end else begin
                        w_wr.count = 2'd1;
                        w_wr.res0  = '{code_unit: cp[15:0], kind: KIND_UNIT,
                                       last_of_run: 1'b1};
                    end
                end else if (cp <= CP_MAX) begin
                    w_wr.count = 2'd2;
                    w_wr.res0  = '{code_unit: SURR_HI_BASE | {6'd0, v[19:10]},
                                   kind: KIND_UNIT, last_of_run: 1'b0};
                    w_wr.res1  = '{code_unit: SURR_LO_BASE | {6'd0, v[9:0]},
                                   kind: KIND_UNIT, last_of_run: 1'b1};
                end else begin
                    fail = 1'b1;
                end
            end
        end

        // Any error reports once and clears the partial code point.
        if (fail) begin
            n_pcp      = '0;
            n_rem      = '0;
            n_err      = 1'b1;
            w_wr.count = 2'd1;
            w_wr.res0  = '{code_unit: 16'd0, kind: KIND_ERROR, last_of_run: 1'b1};
            w_wr.res1  = '0;
        end

        if (!r_in_vld) begin
            w_wr.count = 2'd0;
        end
    end

    assign o_wr = w_wr;

endmodule

// ===== sv/u8u16_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// UTF-8 decoder result buffer
// Small register queue that takes up to two results per cycle from the core
// and presents one result per transaction on the output channel.
// ============================================================================
module u8u16_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  u8u16_pkg::t_wr_req                i_wr,
    input  logic                              i_pop,
    output logic                              o_valid,
    output u8u16_pkg::t_result                o_head,
    output logic [u8u16_pkg::RES_CNT_W-1:0]   o_count
);
    import u8u16_pkg::*;

    t_result              r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_head;
    logic [RES_PTR_W-1:0] r_tail;
    logic [RES_CNT_W-1:0] r_count;
    logic [RES_PTR_W-1:0] w_tail1;

    assign w_tail1 = r_tail + RES_PTR_W'(1);

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (i_wr.count != 2'd0) begin
            r_mem[r_tail] <= i_wr.res0;
        end
        if (i_wr.count == 2'd2) begin
            r_mem[w_tail1] <= i_wr.res1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + RES_PTR_W'(i_wr.count);
            r_head  <= r_head + RES_PTR_W'(i_pop);
            r_count <= r_count + RES_CNT_W'(i_wr.count) - RES_CNT_W'(i_pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_head];
    assign o_count = r_count;

endmodule

// ===== sv/u8u16_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// UTF-8 decoder port checker
// Concurrent assertions on the result channel of the decoder, attached to
// the top level by a bind statement.
// ============================================================================
module u8u16_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [15:0] i_code_unit,
    input logic [1:0]  i_kind,
    input logic        i_last
);
    import u8u16_pkg::*;

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // Status results carry a zero code unit.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_kind != KIND_UNIT) |-> (i_code_unit == 16'd0))
        else $error("status result with nonzero code unit");

    // End marks always close the run of their byte.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_kind == KIND_END_OK || i_kind == KIND_END_ERR)) |-> i_last)
        else $error("end mark not last of run");

    // A code unit that does not close its run is a high surrogate.
    a_high_surr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_kind == KIND_UNIT && !i_last)
        |-> (i_code_unit[15:10] == 6'b110110))
        else $error("unfinished run on a non high surrogate");

    // A high surrogate transaction is followed at once by its low surrogate.
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_ready && i_kind == KIND_UNIT && !i_last)
        |=> (i_res_valid && i_kind == KIND_UNIT && i_last
             && i_code_unit[15:10] == 6'b110111))
        else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res_ch.valid),
    .i_res_ready (o_res_ch.ready),
    .i_code_unit (o_res_ch.code_unit),
    .i_kind      (o_res_ch.kind),
    .i_last      (o_res_ch.last_of_run)
);
